/* design/psag_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psag_pkg
// Shared types and constants of the pulse gain sag tracker.
// ----------------------------------------------------------------------------
package psag_pkg;

   localparam int X_FRAC = 16;
   localparam int X_BITS = 21;
   localparam int X_IDX_W = 5;

   localparam logic [1:0] CMD_PULSE = 2'd0;
   localparam logic [1:0] CMD_QUERY = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ORDER = 1'b1;

   localparam logic [63:0] Q62_ONE  = 64'd1 << 62;
   localparam logic [63:0] EXP_BASE = Q62_ONE - (64'd1 << 46) + (64'd1 << 29) - 64'd2731;

   typedef logic [X_BITS-1:0][63:0] fac_table_type;

   typedef struct packed {
      logic start;
      logic use_q62;
   } mul_req_type;

   function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p + (128'd1 << 61);
      return p[125:62];
   endfunction

   // exp(-2^(i-16)) in Q0.62, each entry the rounded square of the previous
   function automatic fac_table_type build_fac_table();
      fac_table_type t;
      logic [63:0] f;
      f = EXP_BASE;
      for (int i = 0; i < X_BITS; i++) begin
         t[i] = f;
         f = q62_mul(f, f);
      end
      return t;
   endfunction

   localparam fac_table_type EXP_FACTORS = build_fac_table();

endpackage

/* design/psag_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psag_mul
// Shared 64x64 multiplier, four 32x32 partial products, rounded right shift.
// ----------------------------------------------------------------------------
module psag_mul #(
   parameter int FRACTION_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  psag_pkg::mul_req_type req,
   input  logic [63:0]           a,
   input  logic [63:0]           b,
   output logic                  done,
   output logic [63:0]           result
);

   logic [63:0]  a_ff, a_in, b_ff, b_in;
   logic [127:0] acc_ff, acc_in;
   logic [1:0]   step_ff, step_in;
   logic         busy_ff, busy_in, done_ff, done_in, q62_ff, q62_in;

   logic [31:0]  a_half, b_half;
   logic [63:0]  prod;
   logic [1:0]   amt;
   logic [127:0] sum_q62, sum_f;

   assign a_half = step_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign b_half = step_ff[0] ? b_ff[63:32] : b_ff[31:0];
   assign prod   = {32'd0, a_half} * {32'd0, b_half};
   assign amt    = {1'b0, step_ff[1]} + {1'b0, step_ff[0]};

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      q62_in  = q62_ff;
      done_in = 1'b0;
      if (req.start) begin
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
         q62_in  = req.use_q62;
      end else if (busy_ff) begin
         acc_in  = acc_ff + ({64'd0, prod} << {amt, 5'd0});
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      step_ff <= step_in;
      q62_ff  <= q62_in;
   end

   // round half up, then drop the fraction
   assign sum_q62 = acc_ff + (128'd1 << 61);
   assign sum_f   = acc_ff + (128'd1 << (FRACTION_BITS - 1));
   assign result  = q62_ff ? sum_q62[125:62] : 64'(sum_f >> FRACTION_BITS);
   assign done    = done_ff;

endmodule

/* design/pulse_gain_sag_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_gain_sag_tracker
// Detector gain sag tracker: exponential recovery between pulses, drops.
// ----------------------------------------------------------------------------
// Clear, unused command, query before any pulse, first pulse and out-of-order items
// go straight to the result. A dt of 0 or at least 32*tau skips the exponent; otherwise
// dt is divided by tau, the 21-bit quotient sets which exp factors are multiplied in on
// the shared 32x32 multiplier, then the deficit is relaxed and, for a pulse, the drop applied.
// Reset (synchronous): deficit 0, no pulse seen, recovery_time 1152.
module pulse_gain_sag_tracker #(
   parameter int TIME_WIDTH    = 16,
   parameter int FRACTION_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_command,
   input  logic [TIME_WIDTH-1:0]    req_event_time,
   input  logic [FRACTION_BITS-1:0] req_drop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [FRACTION_BITS:0]   rsp_gain,
   output logic                     rsp_status,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [15:0]              csr_data
);

   localparam int F      = FRACTION_BITS;
   localparam int NUM_W  = TIME_WIDTH + psag_pkg::X_FRAC;
   localparam int CNT_W  = $clog2(NUM_W + 1);
   localparam int CMP_W  = TIME_WIDTH + 22;
   localparam logic [F:0] ONE = (F+1)'(1) << F;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_DIV    = 8'b0000_0010,
      S_EXP    = 8'b0000_0100,
      S_EXPW   = 8'b0000_1000,
      S_RELAX  = 8'b0001_0000,
      S_RELAXW = 8'b0010_0000,
      S_DROPW  = 8'b0100_0000,
      S_FINISH = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [15:0]             tau_ff, tau_in;
   logic [F-1:0]            deficit_ff, deficit_in;
   logic [TIME_WIDTH-1:0]   last_ff, last_in;
   logic                    seen_ff, seen_in;

   logic                    cmd_query_ff, cmd_query_in;
   logic [TIME_WIDTH-1:0]   time_ff, time_in;
   logic [F-1:0]            drop_ff, drop_in;
   logic [NUM_W-1:0]        num_ff, num_in;
   logic [15:0]             rem_ff, rem_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [psag_pkg::X_BITS-1:0]  quo_ff, quo_in;
   logic [psag_pkg::X_IDX_W-1:0] idx_ff, idx_in;
   logic [63:0]             acc_ff, acc_in;
   logic [F:0]              factor_ff, factor_in;
   logic [F-1:0]            relaxed_ff, relaxed_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [F:0]              gain_ff, gain_in;
   logic                    status_ff, status_in;
   logic [F:0]              rsp_gain_ff, rsp_gain_in;
   logic                    rsp_status_ff, rsp_status_in;

   psag_pkg::mul_req_type   mreq;
   logic [63:0]             mul_a, mul_b, mul_result;
   logic                    mul_done;

   logic [TIME_WIDTH-1:0]   dt;
   logic [16:0]             trial;
   logic [63:0]             exp_round;
   logic [F+1:0]            new_deficit;

   psag_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .req    (mreq),
      .a      (mul_a),
      .b      (mul_b),
      .done   (mul_done),
      .result (mul_result)
   );

   assign req_ready  = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_gain   = rsp_gain_ff;
   assign rsp_status = rsp_status_ff;

   assign dt    = req_event_time - last_ff;
   assign trial = {rem_ff, num_ff[NUM_W-1]};
   // scale the Q0.62 product to Q0.F, round half up
   assign exp_round   = (acc_ff + (64'd1 << (61 - F))) >> (62 - F);
   assign new_deficit = {2'b00, relaxed_ff} + {2'b00, drop_ff} - (F+2)'(mul_result);

   always_comb begin
      state_in      = state_ff;
      tau_in        = tau_ff;
      deficit_in    = deficit_ff;
      last_in       = last_ff;
      seen_in       = seen_ff;
      cmd_query_in  = cmd_query_ff;
      time_in       = time_ff;
      drop_in       = drop_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      quo_in        = quo_ff;
      idx_in        = idx_ff;
      acc_in        = acc_ff;
      factor_in     = factor_ff;
      relaxed_in    = relaxed_ff;
      rsp_valid_in  = rsp_valid_ff;
      gain_in       = gain_ff;
      status_in     = status_ff;
      rsp_gain_in   = rsp_gain_ff;
      rsp_status_in = rsp_status_ff;
      mreq          = '0;
      mul_a         = 64'(deficit_ff);
      mul_b         = 64'(factor_ff);

      if (csr_valid) begin
         tau_in = csr_data;
      end
      // drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_query_in = (req_command == psag_pkg::CMD_QUERY);
               time_in      = req_event_time;
               drop_in      = req_drop;
               status_in    = psag_pkg::STATUS_OK;
               gain_in      = '0;
               state_in     = S_FINISH;
               if (req_command == psag_pkg::CMD_CLEAR) begin
                  deficit_in = '0;
                  last_in    = '0;
                  seen_in    = 1'b0;
                  gain_in    = ONE;
               end else if (req_command == psag_pkg::CMD_PULSE ||
                            req_command == psag_pkg::CMD_QUERY) begin
                  if (seen_ff && req_event_time < last_ff) begin
                     status_in = psag_pkg::STATUS_ORDER;
                  end else if (!seen_ff) begin
                     if (req_command == psag_pkg::CMD_QUERY) begin
                        gain_in = ONE;
                     end else begin
                        // first pulse of a fill: take the drop as is
                        deficit_in = req_drop;
                        last_in    = req_event_time;
                        seen_in    = 1'b1;
                        gain_in    = ONE - {1'b0, req_drop};
                     end
                  end else if (dt == '0) begin
                     factor_in = ONE;
                     state_in  = S_RELAX;
                  end else if (tau_ff == '0 ||
                               CMP_W'(dt) >= (CMP_W'(tau_ff) << 5)) begin
                     factor_in = '0;
                     state_in  = S_RELAX;
                  end else begin
                     num_in   = {dt, psag_pkg::X_FRAC'(0)};
                     rem_in   = '0;
                     quo_in   = '0;
                     cnt_in   = CNT_W'(NUM_W);
                     state_in = S_DIV;
                  end
               end
            end
         end

         S_DIV: begin
            // one restoring step per cycle
            num_in = num_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (trial >= {1'b0, tau_ff}) begin
               rem_in = 16'(trial - {1'b0, tau_ff});
               quo_in = {quo_ff[psag_pkg::X_BITS-2:0], 1'b1};
            end else begin
               rem_in = trial[15:0];
               quo_in = {quo_ff[psag_pkg::X_BITS-2:0], 1'b0};
            end
            if (cnt_ff == CNT_W'(1)) begin
               acc_in   = psag_pkg::Q62_ONE;
               idx_in   = '0;
               state_in = S_EXP;
            end
         end

         S_EXP: begin
            mul_a = acc_ff;
            mul_b = psag_pkg::EXP_FACTORS[idx_ff];
            if (idx_ff == psag_pkg::X_IDX_W'(psag_pkg::X_BITS)) begin
               factor_in = (F+1)'(exp_round);
               state_in  = S_RELAX;
            end else if (quo_ff[idx_ff]) begin
               mreq.start   = 1'b1;
               mreq.use_q62 = 1'b1;
               state_in     = S_EXPW;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         S_EXPW: begin
            if (mul_done) begin
               acc_in   = mul_result;
               idx_in   = idx_ff + 1'b1;
               state_in = S_EXP;
            end
         end

         S_RELAX: begin
            mreq.start = 1'b1;
            state_in   = S_RELAXW;
         end

         S_RELAXW: begin
            mul_a = 64'(mul_result[F-1:0]);
            mul_b = 64'(drop_ff);
            if (mul_done) begin
               relaxed_in = mul_result[F-1:0];
               if (cmd_query_ff) begin
                  gain_in  = ONE - {1'b0, mul_result[F-1:0]};
                  state_in = S_FINISH;
               end else begin
                  mreq.start = 1'b1;
                  state_in   = S_DROPW;
               end
            end
         end

         S_DROPW: begin
            if (mul_done) begin
               // saturate just below full deficit
               if (new_deficit > (F+2)'({F{1'b1}})) begin
                  deficit_in = '1;
                  gain_in    = ONE - {1'b0, {F{1'b1}}};
               end else begin
                  deficit_in = new_deficit[F-1:0];
                  gain_in    = ONE - {1'b0, new_deficit[F-1:0]};
               end
               last_in  = time_ff;
               seen_in  = 1'b1;
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            // hold until the output register is free, then load it
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_gain_in   = gain_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tau_ff       <= 16'd1152;
         deficit_ff   <= '0;
         last_ff      <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tau_ff       <= tau_in;
         deficit_ff   <= deficit_in;
         last_ff      <= last_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_query_ff  <= cmd_query_in;
      time_ff       <= time_in;
      drop_ff       <= drop_in;
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      quo_ff        <= quo_in;
      idx_ff        <= idx_in;
      acc_ff        <= acc_in;
      factor_ff     <= factor_in;
      relaxed_ff    <= relaxed_in;
      gain_ff       <= gain_in;
      status_ff     <= status_in;
      rsp_gain_ff   <= rsp_gain_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

/* bench/tb_pulse_gain_sag_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pulse_gain_sag_tracker
// Self-checking bench for the gain sag tracker. A bit-exact software tracker
// (range-reduced exp table, Q0.62 products, saturating drops) predicts each
// transaction's gain and status. Directed corners come first, then random
// time-ordered pulse/query/clear streams under several recovery times, with
// random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_pulse_gain_sag_tracker;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_OFF_CYCLES = 700;

   typedef struct {
      logic [32:0] gain;
      logic        status;
   } gain_result_type;

   // Bit-exact tracker plus the queue of gains it still expects to see.
   class gain_sag_scoreboard;
      logic [63:0]     exp_factor[21];
      logic [15:0]     tau;
      logic [31:0]     deficit;
      logic [15:0]     last_time;
      logic            seen;
      gain_result_type pending_gains[$];
      int              errors;

      function new();
         exp_factor[0] = (64'd1 << 62) - (64'd1 << 46) + (64'd1 << 29) - 64'd2731;
         for (int i = 1; i < 21; i++)
            exp_factor[i] = round_mul(exp_factor[i-1], exp_factor[i-1], 62);
         tau = 16'd1152;
         deficit = '0;
         last_time = '0;
         seen = 1'b0;
         errors = 0;
      endfunction

      function logic [63:0] round_mul(logic [63:0] a, logic [63:0] b, int f);
         logic [127:0] p;
         p = {64'd0, a} * {64'd0, b};
         p = p + (128'd1 << (f - 1));
         return 64'(p >> f);
      endfunction

      // exp(-dt/tau) in Q0.32
      function logic [63:0] decay(logic [63:0] dt);
         logic [63:0] xq;
         logic [63:0] acc;
         if (dt == 0) return 64'd1 << 32;
         if (tau == 0 || dt >= 64'd32 * tau) return 64'd0;
         xq = (dt << 16) / tau;
         acc = 64'd1 << 62;
         for (int i = 0; i < 21; i++)
            if (xq[i]) acc = round_mul(acc, exp_factor[i], 62);
         return (acc + (64'd1 << 29)) >> 30;
      endfunction

      function logic [63:0] relaxed(logic [15:0] t);
         return round_mul({32'd0, deficit}, decay({48'd0, t} - {48'd0, last_time}), 32);
      endfunction

      function void set_tau(logic [15:0] v);
         tau = v;
      endfunction

      function int pending();
         return pending_gains.size();
      endfunction

      function void note_item(logic [1:0] cmd, logic [15:0] t, logic [31:0] p);
         gain_result_type r;
         logic [63:0] d, nd;
         r.gain = '0;
         r.status = psag_pkg::STATUS_OK;
         if (cmd == psag_pkg::CMD_CLEAR) begin
            deficit = '0;
            last_time = '0;
            seen = 1'b0;
            r.gain = 33'h1_0000_0000;
         end else if (cmd != CMD_UNUSED) begin
            if (seen && t < last_time) begin
               r.status = psag_pkg::STATUS_ORDER;
            end else if (cmd == psag_pkg::CMD_QUERY) begin
               r.gain = seen ? 33'h1_0000_0000 - 33'(relaxed(t)) : 33'h1_0000_0000;
            end else begin
               if (!seen) begin
                  deficit = p;
               end else begin
                  d = relaxed(t);
                  nd = d + {32'd0, p} - round_mul(d, {32'd0, p}, 32);
                  deficit = (nd > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nd[31:0];
               end
               last_time = t;
               seen = 1'b1;
               r.gain = 33'h1_0000_0000 - {1'b0, deficit};
            end
         end
         pending_gains = {pending_gains, r};
      endfunction

      function void check_result(logic [32:0] gain, logic status);
         gain_result_type e;
         if (pending_gains.size() == 0) begin
            $error("unexpected result: gain %h status %0d", gain, status);
            errors++;
            return;
         end
         e = pending_gains.pop_front();
         if (gain !== e.gain) begin
            $error("gain: expected %h, actual %h", e.gain, gain);
            errors++;
         end
         if (status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, status);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = psag_pkg::CMD_CLEAR;
   logic [15:0] req_event_time = '0;
   logic [31:0] req_drop = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [32:0] rsp_gain;
   logic        rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   gain_sag_scoreboard sb = new();
   bit hold_off_request = 1'b0;
   int idle_cycles = 0;
   int t_now = 0;

   pulse_gain_sag_tracker u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_event_time(req_event_time), .req_drop(req_drop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_gain(rsp_gain), .rsp_status(rsp_status),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Check every result transaction against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_gain, rsp_status);
   end

   // Count cycles without any transaction; bail out if the block hangs.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
            || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Receiver: random ready pattern; on request hold off long enough to
   // back the block up into its input.
   initial begin
      int len;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 99) < 45) begin
            rsp_ready <= 1'b1;
            len = $urandom_range(0, 19);
            repeat (len) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            len = ($urandom_range(0, 99) < 6) ? $urandom_range(30, 120) : $urandom_range(0, 3);
            repeat (len) @(posedge clock);
         end
      end
   end

   // Offer one transaction, wait for it to be taken, then maybe idle.
   task automatic send_item(logic [1:0] cmd, logic [15:0] t, logic [31:0] p);
      int gap, r;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_event_time <= t;
      req_drop <= p;
      do @(posedge clock); while (!req_ready);
      sb.note_item(cmd, t, p);
      r = $urandom_range(0, 99);
      gap = (r < 35) ? 0 : (r < 93) ? $urandom_range(1, 4) : $urandom_range(20, 80);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every expected result is back.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Write the recovery time only with the block idle.
   task automatic write_tau(logic [15:0] v);
      drain();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      sb.set_tau(v);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_drop();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 32'd0;
      if (r < 20) return 32'hFFFF_FFFF;
      if (r < 40) return $urandom_range(0, 1 << 20);
      return $urandom;
   endfunction

   // One random transaction: mostly in-order streams, some out of order.
   task automatic send_random();
      int r, s, step, span, t;
      logic [1:0] cmd;
      r = $urandom_range(0, 99);
      cmd = (r < 52) ? psag_pkg::CMD_PULSE : (r < 82) ? psag_pkg::CMD_QUERY :
            (r < 87) ? psag_pkg::CMD_CLEAR : (r < 90) ? CMD_UNUSED : psag_pkg::CMD_PULSE;
      s = $urandom_range(0, 99);
      span = (sb.tau < 8) ? 8 : sb.tau;
      if (s < 10 && sb.seen && sb.last_time > 0) begin
         // drop back before the last pulse
         t = $urandom_range(0, sb.last_time - 1);
      end else begin
         if (s < 20) step = 0;
         else if (s < 85) step = $urandom_range(0, span / 2);
         else step = $urandom_range(0, 40 * span);
         t = t_now + step;
         if (t > 65535) begin
            send_item(psag_pkg::CMD_CLEAR, 16'($urandom), 32'($urandom));
            t_now = 0;
            t = $urandom_range(0, 255);
         end
         if (cmd != psag_pkg::CMD_CLEAR) t_now = t;
      end
      if (cmd == psag_pkg::CMD_CLEAR) t_now = 0;
      send_item(cmd, 16'(t), pick_drop());
   endtask

   initial begin
      logic [15:0] tau_list[6];
      tau_list = '{16'd1152, 16'd1, 16'd65535, 16'd0, 16'd64, 16'd300};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners at the reset recovery time
      send_item(psag_pkg::CMD_QUERY, 16'd5, 32'hFFFF_FFFF);   // query before any pulse
      send_item(psag_pkg::CMD_PULSE, 16'd0, 32'd0);           // first pulse, no drop
      send_item(psag_pkg::CMD_PULSE, 16'd0, 32'hFFFF_FFFF);   // equal time, full deficit
      send_item(psag_pkg::CMD_QUERY, 16'd0, 32'd0);
      send_item(psag_pkg::CMD_PULSE, 16'd100, 32'd1);
      send_item(psag_pkg::CMD_QUERY, 16'd50, 32'd0);          // out of order query
      send_item(psag_pkg::CMD_PULSE, 16'd50, 32'h1234_5678);  // out of order pulse
      send_item(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(psag_pkg::CMD_QUERY, 16'd36964, 32'd0);       // exactly 32 tau later
      send_item(psag_pkg::CMD_QUERY, 16'd36963, 32'd0);       // just inside the table
      send_item(psag_pkg::CMD_PULSE, 16'hFFFF, 32'h8000_0000);
      send_item(psag_pkg::CMD_QUERY, 16'hFFFF, 32'd0);
      send_item(psag_pkg::CMD_CLEAR, 16'hFFFF, 32'hFFFF_FFFF); // clear ignores its fields
      send_item(psag_pkg::CMD_QUERY, 16'hFFFF, 32'd0);
      send_item(psag_pkg::CMD_PULSE, 16'hFFFF, 32'hAAAA_AAAA);
      send_item(psag_pkg::CMD_PULSE, 16'hFFFF, 32'h5555_5555);
      send_item(psag_pkg::CMD_PULSE, 16'd1, 32'd7);           // out of order, low time
      send_item(psag_pkg::CMD_CLEAR, 16'd0, 32'd0);
      t_now = 0;

      // Random phases, one recovery time each, draining between them
      for (int ph = 0; ph < 6; ph++) begin
         write_tau(tau_list[ph]);
         send_item(psag_pkg::CMD_CLEAR, 16'd0, 32'd0);
         t_now = 0;
         for (int n = 0; n < 190; n++) begin
            if (ph == 2 && n == 20) hold_off_request = 1'b1;
            send_random();
         end
         drain();   // sender pause until every result is back
      end

      drain();
      repeat (300) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
